[rtl/tensor_layout_permute_addresser_core_assert.svh]
// assertion macros used by the core rtl file
`ifndef TENSOR_LAYOUT_PERMUTE_ADDRESSER_CORE_ASSERT_SVH
`define TENSOR_LAYOUT_PERMUTE_ADDRESSER_CORE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define TLPA_ASSERT_NOW(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tlpa same-cycle check failed");

// next-cycle implication, checked out of reset
`define TLPA_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tlpa next-cycle check failed");

`endif

[rtl/tlpa_pkg.sv]
`default_nettype none
package tlpa_pkg;

    localparam int MAX_DIM = 4096;
    // counter width: holds 0 .. MAX_DIM-1
    localparam int DIM_W   = $clog2(MAX_DIM);
    // dimension value width: holds 1 .. MAX_DIM
    localparam int DIMV_W  = DIM_W + 1;
    localparam int CFG_W   = 13;
    localparam int ADDR_W  = 48;
    localparam int DATA_W  = 32;
    localparam int IDX_W   = 3;
    localparam int PROD1_W = 2 * DIMV_W;
    localparam int PROD2_W = 3 * DIMV_W;

    typedef enum logic [IDX_W-1:0] {
        REG_MODE      = 3'd0,
        REG_DIM_BATCH = 3'd1,
        REG_DIM_PLANE = 3'd2,
        REG_DIM_ROW   = 3'd3,
        REG_DIM_COL   = 3'd4
    } cfg_reg_t;

    typedef enum logic [1:0] {
        SS_IDLE  = 2'd0,
        SS_PROD1 = 2'd1,
        SS_PROD2 = 2'd2
    } stride_state_t;

    // strides of the permuted walk
    typedef struct packed {
        logic                  busy;
        logic [DIMV_W-1:0]     inner;   // column step
        logic [PROD1_W-1:0]    mid;     // row step
        logic [PROD2_W-1:0]    outer;   // step of the non-unit outer counter
    } stride_t;

    // written dim value -> effective size minus one
    function automatic logic [DIM_W-1:0] dim_minus_one(input logic [CFG_W-1:0] v);
        logic [DIM_W-1:0] r;
        if (v == '0)
            r = '0;
        else if (v > CFG_W'(MAX_DIM))
            r = DIM_W'(MAX_DIM - 1);
        else
            r = DIM_W'(v - CFG_W'(1));
        return r;
    endfunction

endpackage
`default_nettype wire

[rtl/tensor_layout_permute_addresser_core.sv]
// throughput: one item per cycle unless a stalled output, a config write or a stride update holds it off;
// an accepted item sits in the output register, which is refilled while it is being taken
// a write to a listed register restarts the walk and recomputes the strides in two multiply steps,
// holding off items while the write is on the port and during both multiply steps
// reset (rst_n low, asynchronous): mode 0, all dims 1, counters zero, output empty
`default_nettype none
`include "tensor_layout_permute_addresser_core_assert.svh"
module tensor_layout_permute_addresser_core (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // configuration write channel
    input  wire logic                           cfg_valid,
    output      logic                           cfg_ready,
    input  wire logic [tlpa_pkg::IDX_W-1:0]     cfg_index,
    input  wire logic [tlpa_pkg::CFG_W-1:0]     cfg_data,
    // input item channel
    input  wire logic                           in_valid,
    output      logic                           in_ready,
    input  wire logic [tlpa_pkg::DATA_W-1:0]    element,
    // result item channel
    output      logic                           out_valid,
    input  wire logic                           out_ready,
    output      logic [tlpa_pkg::DATA_W-1:0]    element_out,
    output      logic [tlpa_pkg::ADDR_W-1:0]    read_address,
    output      logic [tlpa_pkg::ADDR_W-1:0]    write_address,
    output      logic                           last_element
);

    localparam int AW = tlpa_pkg::ADDR_W;
    localparam int DW = tlpa_pkg::DIM_W;

    // configuration, dims kept as effective size minus one
    logic [1:0]    mode_reg;
    logic [DW-1:0] batch_m1_reg, plane_m1_reg, row_m1_reg, col_m1_reg;
    logic          cfg_fire;
    logic          cfg_hit;

    // walk counters
    logic [DW-1:0] batch_idx_reg, plane_idx_reg, row_idx_reg, col_idx_reg;
    logic [DW-1:0] batch_idx_next, plane_idx_next, row_idx_next, col_idx_next;
    logic [AW-1:0] lin_reg, lin_next;

    // permuted index p kept as a running sum, with the partial sums at
    // the start of the current row, plane and batch
    logic [AW-1:0] perm_reg, perm_next;
    logic [AW-1:0] base_row_reg, base_row_next;
    logic [AW-1:0] base_plane_reg, base_plane_next;
    logic [AW-1:0] base_batch_reg, base_batch_next;

    // output register
    logic                           out_valid_reg;
    logic [tlpa_pkg::DATA_W-1:0]    element_reg;
    logic [AW-1:0]                  read_addr_reg, write_addr_reg;
    logic                           last_reg;

    tlpa_pkg::stride_t stride;
    logic [AW-1:0] step_col, step_row, step_plane, step_batch;
    logic [AW-1:0] sum_col, sum_row, sum_plane, sum_batch;
    logic          col_end, row_end, plane_end, batch_end, last_now;
    logic          in_fire;

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;

    // only indexes in the register list act, and only they restart the walk
    always_comb
    begin
        unique case (tlpa_pkg::cfg_reg_t'(cfg_index)) inside
            tlpa_pkg::REG_MODE,
            tlpa_pkg::REG_DIM_BATCH,
            tlpa_pkg::REG_DIM_PLANE,
            tlpa_pkg::REG_DIM_ROW,
            tlpa_pkg::REG_DIM_COL: cfg_hit = 1'b1;
            default:               cfg_hit = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= '0;
            batch_m1_reg <= '0;
            plane_m1_reg <= '0;
            row_m1_reg   <= '0;
            col_m1_reg   <= '0;
        end
        else if (cfg_fire)
        begin
            unique case (tlpa_pkg::cfg_reg_t'(cfg_index))
                tlpa_pkg::REG_MODE:      mode_reg     <= cfg_data[1:0];
                tlpa_pkg::REG_DIM_BATCH: batch_m1_reg <= tlpa_pkg::dim_minus_one(cfg_data);
                tlpa_pkg::REG_DIM_PLANE: plane_m1_reg <= tlpa_pkg::dim_minus_one(cfg_data);
                tlpa_pkg::REG_DIM_ROW:   row_m1_reg   <= tlpa_pkg::dim_minus_one(cfg_data);
                tlpa_pkg::REG_DIM_COL:   col_m1_reg   <= tlpa_pkg::dim_minus_one(cfg_data);
                default:                 mode_reg     <= mode_reg;
            endcase
        end
    end

    tlpa_stride u_stride (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (cfg_fire && cfg_hit),
        .batch_mode (mode_reg[1]),
        .batch_m1   (batch_m1_reg),
        .plane_m1   (plane_m1_reg),
        .row_m1     (row_m1_reg),
        .col_m1     (col_m1_reg),
        .stride     (stride)
    );

    // channel modes: p = i*(r*c*z) + j + k*(c*z) + m*z
    // batch modes:   p = i + j*(r*c*b) + k*(c*b) + m*b
    assign step_col   = AW'(stride.inner);
    assign step_row   = AW'(stride.mid);
    assign step_plane = mode_reg[1] ? AW'(stride.outer) : AW'(1);
    assign step_batch = mode_reg[1] ? AW'(1) : AW'(stride.outer);

    assign sum_col   = perm_reg + step_col;
    assign sum_row   = base_row_reg + step_row;
    assign sum_plane = base_plane_reg + step_plane;
    assign sum_batch = base_batch_reg + step_batch;

    assign col_end   = (col_idx_reg == col_m1_reg);
    assign row_end   = (row_idx_reg == row_m1_reg);
    assign plane_end = (plane_idx_reg == plane_m1_reg);
    assign batch_end = (batch_idx_reg == batch_m1_reg);
    assign last_now  = col_end && row_end && plane_end && batch_end;

    // items wait while strides are recomputed, a write is on the port, or the output is full and not taken
    assign in_ready = !stride.busy && !cfg_valid && (!out_valid_reg || out_ready);
    assign in_fire  = in_valid && in_ready;

    always_comb
    begin
        batch_idx_next  = batch_idx_reg;
        plane_idx_next  = plane_idx_reg;
        row_idx_next    = row_idx_reg;
        col_idx_next    = col_idx_reg;
        lin_next        = lin_reg + AW'(1);
        perm_next       = perm_reg;
        base_row_next   = base_row_reg;
        base_plane_next = base_plane_reg;
        base_batch_next = base_batch_reg;
        if (last_now)
        begin
            batch_idx_next  = '0;
            plane_idx_next  = '0;
            row_idx_next    = '0;
            col_idx_next    = '0;
            lin_next        = '0;
            perm_next       = '0;
            base_row_next   = '0;
            base_plane_next = '0;
            base_batch_next = '0;
        end
        else if (!col_end)
        begin
            col_idx_next = col_idx_reg + DW'(1);
            perm_next    = sum_col;
        end
        else if (!row_end)
        begin
            col_idx_next  = '0;
            row_idx_next  = row_idx_reg + DW'(1);
            base_row_next = sum_row;
            perm_next     = sum_row;
        end
        else if (!plane_end)
        begin
            col_idx_next    = '0;
            row_idx_next    = '0;
            plane_idx_next  = plane_idx_reg + DW'(1);
            base_plane_next = sum_plane;
            base_row_next   = sum_plane;
            perm_next       = sum_plane;
        end
        else
        begin
            col_idx_next    = '0;
            row_idx_next    = '0;
            plane_idx_next  = '0;
            batch_idx_next  = batch_idx_reg + DW'(1);
            base_batch_next = sum_batch;
            base_plane_next = sum_batch;
            base_row_next   = sum_batch;
            perm_next       = sum_batch;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            batch_idx_reg  <= '0;
            plane_idx_reg  <= '0;
            row_idx_reg    <= '0;
            col_idx_reg    <= '0;
            lin_reg        <= '0;
            perm_reg       <= '0;
            base_row_reg   <= '0;
            base_plane_reg <= '0;
            base_batch_reg <= '0;
        end
        else if (cfg_fire && cfg_hit)
        begin
            // any register write restarts the walk at element zero
            batch_idx_reg  <= '0;
            plane_idx_reg  <= '0;
            row_idx_reg    <= '0;
            col_idx_reg    <= '0;
            lin_reg        <= '0;
            perm_reg       <= '0;
            base_row_reg   <= '0;
            base_plane_reg <= '0;
            base_batch_reg <= '0;
        end
        else if (in_fire)
        begin
            batch_idx_reg  <= batch_idx_next;
            plane_idx_reg  <= plane_idx_next;
            row_idx_reg    <= row_idx_next;
            col_idx_reg    <= col_idx_next;
            lin_reg        <= lin_next;
            perm_reg       <= perm_next;
            base_row_reg   <= base_row_next;
            base_plane_reg <= base_plane_next;
            base_batch_reg <= base_batch_next;
        end
    end

    // output register: valid is control, the rest is payload
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (in_fire)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    // odd modes read at p and write at s, even modes the other way round
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            element_reg    <= element;
            read_addr_reg  <= mode_reg[0] ? perm_reg : lin_reg;
            write_addr_reg <= mode_reg[0] ? lin_reg : perm_reg;
            last_reg       <= last_now;
        end
    end

    assign out_valid     = out_valid_reg;
    assign element_out   = element_reg;
    assign read_address  = read_addr_reg;
    assign write_address = write_addr_reg;
    assign last_element  = last_reg;

    `TLPA_ASSERT_NOW(a_no_item_while_busy, stride.busy, !in_ready)
    `TLPA_ASSERT_NEXT(a_cfg_starts_stride, cfg_fire && cfg_hit, stride.busy)
    `TLPA_ASSERT_NEXT(a_wrap_clears_walk, in_fire && last_now && !cfg_fire,
                      lin_reg == '0 && perm_reg == '0 && col_idx_reg == '0)
    `TLPA_ASSERT_NOW(a_col_in_range, 1'b1, col_idx_reg <= col_m1_reg)
    `TLPA_ASSERT_NEXT(a_item_lands_in_output, in_fire, out_valid_reg)

endmodule
`default_nettype wire

[rtl/tlpa_stride.sv]
`default_nettype none
module tlpa_stride (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic                          batch_mode,
    input  wire logic [tlpa_pkg::DIM_W-1:0]    batch_m1,
    input  wire logic [tlpa_pkg::DIM_W-1:0]    plane_m1,
    input  wire logic [tlpa_pkg::DIM_W-1:0]    row_m1,
    input  wire logic [tlpa_pkg::DIM_W-1:0]    col_m1,
    output tlpa_pkg::stride_t                  stride
);

    tlpa_pkg::stride_state_t state_reg, state_next;
    logic [tlpa_pkg::PROD1_W-1:0] prod1_reg, prod1_next;
    logic [tlpa_pkg::PROD2_W-1:0] prod2_reg, prod2_next;
    logic [tlpa_pkg::DIMV_W-1:0]  sel_dim;
    logic [tlpa_pkg::DIMV_W-1:0]  col_dim;
    logic [tlpa_pkg::DIMV_W-1:0]  row_dim;

    // batch modes step by the batch size, channel modes by the plane size
    assign sel_dim = batch_mode ? tlpa_pkg::DIMV_W'(batch_m1) + tlpa_pkg::DIMV_W'(1)
                                : tlpa_pkg::DIMV_W'(plane_m1) + tlpa_pkg::DIMV_W'(1);
    assign col_dim = tlpa_pkg::DIMV_W'(col_m1) + tlpa_pkg::DIMV_W'(1);
    assign row_dim = tlpa_pkg::DIMV_W'(row_m1) + tlpa_pkg::DIMV_W'(1);

    always_comb
    begin
        state_next = state_reg;
        if (start)
            state_next = tlpa_pkg::SS_PROD1;
        else
        begin
            unique case (state_reg)
                tlpa_pkg::SS_IDLE:  state_next = tlpa_pkg::SS_IDLE;
                tlpa_pkg::SS_PROD1: state_next = tlpa_pkg::SS_PROD2;
                tlpa_pkg::SS_PROD2: state_next = tlpa_pkg::SS_IDLE;
                default:            state_next = tlpa_pkg::SS_IDLE;
            endcase
        end
    end

    always_comb
    begin
        prod1_next = prod1_reg;
        prod2_next = prod2_reg;
        unique case (state_reg)
            tlpa_pkg::SS_PROD1:
                prod1_next = tlpa_pkg::PROD1_W'(col_dim) * tlpa_pkg::PROD1_W'(sel_dim);
            tlpa_pkg::SS_PROD2:
                prod2_next = tlpa_pkg::PROD2_W'(row_dim) * tlpa_pkg::PROD2_W'(prod1_reg);
            default:
            begin
                prod1_next = prod1_reg;
                prod2_next = prod2_reg;
            end
        endcase
    end

    // reset values match all dims at one
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tlpa_pkg::SS_IDLE;
            prod1_reg <= tlpa_pkg::PROD1_W'(1);
            prod2_reg <= tlpa_pkg::PROD2_W'(1);
        end
        else
        begin
            state_reg <= state_next;
            prod1_reg <= prod1_next;
            prod2_reg <= prod2_next;
        end
    end

    assign stride.busy  = (state_reg != tlpa_pkg::SS_IDLE);
    assign stride.inner = sel_dim;
    assign stride.mid   = prod1_reg;
    assign stride.outer = prod2_reg;

endmodule
`default_nettype wire

[dv/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

    // layout codes held in the mode register
    typedef enum logic [1:0] {
        CH_LAST  = 2'd0,
        CH_FIRST = 2'd1,
        BT_LAST  = 2'd2,
        BT_FIRST = 2'd3
    } layout_t;

    // one result item as the block should present it
    typedef struct packed {
        logic [tlpa_pkg::DATA_W-1:0] word;
        logic [tlpa_pkg::ADDR_W-1:0] rd_addr;
        logic [tlpa_pkg::ADDR_W-1:0] wr_addr;
        logic                        last;
    } addr_item_t;

    // first register index past the end of the register list
    localparam int FIRST_SPARE_REG = 5;
    localparam int ITEM_GOAL       = 1250;
    localparam int TAIL_ITEMS      = 120;
    localparam int DIM_TOP         = 8191;

    logic                           clk;
    logic                           rst_n;
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [tlpa_pkg::IDX_W-1:0]     cfg_index;
    logic [tlpa_pkg::CFG_W-1:0]     cfg_data;
    logic                           in_valid;
    logic                           in_ready;
    logic [tlpa_pkg::DATA_W-1:0]    element;
    logic                           out_valid;
    logic                           out_ready;
    logic [tlpa_pkg::DATA_W-1:0]    element_out;
    logic [tlpa_pkg::ADDR_W-1:0]    read_address;
    logic [tlpa_pkg::ADDR_W-1:0]    write_address;
    logic                           last_element;

    tensor_layout_permute_addresser_core u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .element       (element),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .element_out   (element_out),
        .read_address  (read_address),
        .write_address (write_address),
        .last_element  (last_element)
    );

    // predictor copy of the registers
    layout_t                        layout_q;
    logic [tlpa_pkg::CFG_W-1:0]     dim_batch_q;
    logic [tlpa_pkg::CFG_W-1:0]     dim_plane_q;
    logic [tlpa_pkg::CFG_W-1:0]     dim_row_q;
    logic [tlpa_pkg::CFG_W-1:0]     dim_col_q;

    // predictor copy of the walk counters
    logic [tlpa_pkg::DIM_W-1:0]     walk_batch;
    logic [tlpa_pkg::DIM_W-1:0]     walk_plane;
    logic [tlpa_pkg::DIM_W-1:0]     walk_row;
    logic [tlpa_pkg::DIM_W-1:0]     walk_col;
    logic [tlpa_pkg::ADDR_W-1:0]    walk_lin;

    // results still owed by the block, oldest first
    addr_item_t           pending_items[$];
    addr_item_t           fresh_item;
    addr_item_t           owed_item;

    int                   mismatches;
    int                   items_sent;
    bit                   tail_calm;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // hard stop well past the slowest legal run
    initial
    begin
        #4_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // a written dim value as the block uses it
    function automatic logic [63:0] eff_size(input logic [tlpa_pkg::CFG_W-1:0] v);
        if (v == '0)
            return 64'd1;
        else if (v > tlpa_pkg::CFG_W'(tlpa_pkg::MAX_DIM))
            return 64'(tlpa_pkg::MAX_DIM);
        else
            return 64'(v);
    endfunction

    task automatic clear_walk();
        walk_batch = '0;
        walk_plane = '0;
        walk_row   = '0;
        walk_col   = '0;
        walk_lin   = '0;
    endtask

    // expected addresses for the element at the current walk position, then step the walk
    task automatic predict_permuted(input logic [tlpa_pkg::DATA_W-1:0] word,
                                    output addr_item_t res);
        logic [63:0]                 b, z, r, c;
        logic [63:0]                 i, j, k, m;
        logic [63:0]                 perm;
        logic [tlpa_pkg::ADDR_W-1:0] lin;
        logic                        fin;
        b = eff_size(dim_batch_q);
        z = eff_size(dim_plane_q);
        r = eff_size(dim_row_q);
        c = eff_size(dim_col_q);
        i = 64'(walk_batch);
        j = 64'(walk_plane);
        k = 64'(walk_row);
        m = 64'(walk_col);
        lin = walk_lin;

        // channel modes move the plane index innermost, batch modes the batch index
        if (layout_q == CH_LAST || layout_q == CH_FIRST)
            perm = ((i * r + k) * c + m) * z + j;
        else
            perm = ((j * r + k) * c + m) * b + i;

        fin = (i + 1 >= b) && (j + 1 >= z) && (k + 1 >= r) && (m + 1 >= c);

        res.word = word;
        // last modes read linearly and scatter, first modes gather and write linearly
        if (layout_q == CH_LAST || layout_q == BT_LAST)
        begin
            res.rd_addr = lin;
            res.wr_addr = perm[tlpa_pkg::ADDR_W-1:0];
        end
        else
        begin
            res.rd_addr = perm[tlpa_pkg::ADDR_W-1:0];
            res.wr_addr = lin;
        end
        res.last = fin;

        if (fin)
        begin
            clear_walk();
        end
        else
        begin
            walk_lin = lin + 1'b1;
            if (m + 1 < c)
            begin
                walk_col = walk_col + 1'b1;
            end
            else
            begin
                walk_col = '0;
                if (k + 1 < r)
                begin
                    walk_row = walk_row + 1'b1;
                end
                else
                begin
                    walk_row = '0;
                    if (j + 1 < z)
                    begin
                        walk_plane = walk_plane + 1'b1;
                    end
                    else
                    begin
                        walk_plane = '0;
                        walk_batch = walk_batch + 1'b1;
                    end
                end
            end
        end
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
            mismatches++;
        end
    endtask

    // monitor: predict on every accepted input item, check every accepted result item
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                predict_permuted(element, fresh_item);
                pending_items.push_back(fresh_item);
            end
            if (out_valid && out_ready)
            begin
                if (pending_items.size() == 0)
                begin
                    $display("%0t: unexpected result item, expected none actual %h %h %h %b",
                             $time, element_out, read_address, write_address, last_element);
                    mismatches++;
                end
                else
                begin
                    owed_item = pending_items.pop_front();
                    check_field("element_out", 64'(owed_item.word), 64'(element_out));
                    check_field("read_address", 64'(owed_item.rd_addr), 64'(read_address));
                    check_field("write_address", 64'(owed_item.wr_addr), 64'(write_address));
                    check_field("last_element", 64'(owed_item.last), 64'(last_element));
                end
            end
        end
    end

    // receiver pacing: stretches with no stalls, stretches with bursty stalls
    initial
    begin : rx_pacing
        int span;
        int stall_odds;
        int stretch;
        out_ready  = 1'b0;
        stall_odds = 0;
        stretch    = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (stretch == 0)
            begin
                stretch    = 150;
                stall_odds = $urandom_range(0, 2);
            end
            stretch--;
            if (!tail_calm && stall_odds != 0 &&
                $urandom_range(0, 7 - 2 * stall_odds) == 0)
            begin
                out_ready <= 1'b0;
                span = $urandom_range(1, 11);
                repeat (span - 1) @(negedge clk);
                stretch = (stretch > span) ? stretch - span : 0;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    // one register write, only called with nothing in flight
    task automatic cfg_write(input logic [tlpa_pkg::IDX_W-1:0] idx,
                             input logic [tlpa_pkg::CFG_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        // a write to a real register restarts the walk, a spare index is ignored
        case (idx)
            tlpa_pkg::REG_MODE:
            begin
                layout_q = layout_t'(data[1:0]);
                clear_walk();
            end
            tlpa_pkg::REG_DIM_BATCH:
            begin
                dim_batch_q = data;
                clear_walk();
            end
            tlpa_pkg::REG_DIM_PLANE:
            begin
                dim_plane_q = data;
                clear_walk();
            end
            tlpa_pkg::REG_DIM_ROW:
            begin
                dim_row_q = data;
                clear_walk();
            end
            tlpa_pkg::REG_DIM_COL:
            begin
                dim_col_q = data;
                clear_walk();
            end
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // present one element and hold it until taken
    task automatic send_element(input logic [tlpa_pkg::DATA_W-1:0] w);
        @(negedge clk);
        in_valid <= 1'b1;
        element  <= w;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        items_sent++;
    endtask

    // sender idle: in_valid held low while element takes random values
    task automatic in_gap(input int n);
        repeat (n)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            element  <= $urandom;
        end
    endtask

    // stop sending and wait until every owed result item has come back
    task automatic drain_results();
        in_gap(1);
        while (pending_items.size() != 0) @(posedge clk);
    endtask

    task automatic set_dims(input logic [tlpa_pkg::CFG_W-1:0] b,
                            input logic [tlpa_pkg::CFG_W-1:0] z,
                            input logic [tlpa_pkg::CFG_W-1:0] r,
                            input logic [tlpa_pkg::CFG_W-1:0] c);
        cfg_write(tlpa_pkg::REG_DIM_BATCH, b);
        cfg_write(tlpa_pkg::REG_DIM_PLANE, z);
        cfg_write(tlpa_pkg::REG_DIM_ROW, r);
        cfg_write(tlpa_pkg::REG_DIM_COL, c);
    endtask

    // mostly tiny dims so whole tensors get walked, now and then zero or oversized
    function automatic logic [tlpa_pkg::CFG_W-1:0] pick_dim();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 80)
            return tlpa_pkg::CFG_W'($urandom_range(1, 4));
        else if (roll < 86)
            return tlpa_pkg::CFG_W'($urandom);
        else if (roll < 90)
            return '0;
        else if (roll < 95)
            return tlpa_pkg::CFG_W'(tlpa_pkg::MAX_DIM);
        else
            return tlpa_pkg::CFG_W'($urandom_range(tlpa_pkg::MAX_DIM + 1, DIM_TOP));
    endfunction

    // reset state: all dims one, so every element is the last one at address zero
    task automatic test_reset_state();
        send_element('0);
        send_element('1);
        drain_results();
    endtask

    // zero dims act as one, dims above the maximum act as the maximum
    task automatic test_dim_clamping();
        cfg_write(tlpa_pkg::REG_MODE, tlpa_pkg::CFG_W'(CH_FIRST));
        set_dims('0, tlpa_pkg::CFG_W'(DIM_TOP), tlpa_pkg::CFG_W'(tlpa_pkg::MAX_DIM),
                 tlpa_pkg::CFG_W'(tlpa_pkg::MAX_DIM + 1));
        repeat (3) send_element($urandom);
        drain_results();
    endtask

    // any write to a real register restarts the walk, a spare index does not
    task automatic test_config_restart();
        cfg_write(tlpa_pkg::REG_MODE, tlpa_pkg::CFG_W'(CH_LAST));
        set_dims(13'd2, 13'd2, 13'd2, 13'd2);
        repeat (3) send_element($urandom);
        drain_results();
        // same value written again still restarts
        cfg_write(tlpa_pkg::REG_DIM_ROW, 13'd2);
        repeat (2) send_element($urandom);
        drain_results();
        for (int x = FIRST_SPARE_REG; x < 2 ** tlpa_pkg::IDX_W; x++)
            cfg_write(tlpa_pkg::IDX_W'(x), tlpa_pkg::CFG_W'($urandom));
        repeat (2) send_element($urandom);
        drain_results();
    endtask

    // every layout over a whole small tensor, ending on the last element
    task automatic test_each_layout();
        layout_t lay;
        for (int x = 0; x < 4; x++)
        begin
            lay = layout_t'(x);
            // high data bits of the mode write are dont-care
            cfg_write(tlpa_pkg::REG_MODE, {(tlpa_pkg::CFG_W - 2)'($urandom), lay});
            if (lay == CH_LAST || lay == CH_FIRST)
                set_dims(13'd1, 13'd2, 13'd1, 13'd2);
            else
                set_dims(13'd2, 13'd1, 13'd1, 13'd2);
            send_element(32'hAAAA_5555);
            send_element(32'h5555_AAAA);
            send_element('1);
            send_element('0);
            drain_results();
        end
    endtask

    // one random setting followed by a run of elements, mostly whole tensors
    task automatic run_phase(input bit calm, input int budget);
        logic [tlpa_pkg::CFG_W-1:0] word;
        logic [63:0]                tensor;
        int                         n;
        bit                         gaps_on;
        // sender waits for the block to go quiet before touching registers
        drain_results();
        if ($urandom_range(0, 1))
        begin
            word = tlpa_pkg::CFG_W'($urandom);
            cfg_write(tlpa_pkg::REG_MODE, word);
        end
        if ($urandom_range(0, 1)) cfg_write(tlpa_pkg::REG_DIM_BATCH, pick_dim());
        if ($urandom_range(0, 1)) cfg_write(tlpa_pkg::REG_DIM_PLANE, pick_dim());
        if ($urandom_range(0, 1)) cfg_write(tlpa_pkg::REG_DIM_ROW, pick_dim());
        if ($urandom_range(0, 1)) cfg_write(tlpa_pkg::REG_DIM_COL, pick_dim());
        if ($urandom_range(0, 7) == 0)
            cfg_write(tlpa_pkg::IDX_W'($urandom_range(FIRST_SPARE_REG,
                                                      2 ** tlpa_pkg::IDX_W - 1)),
                      tlpa_pkg::CFG_W'($urandom));

        tensor = eff_size(dim_batch_q) * eff_size(dim_plane_q) *
                 eff_size(dim_row_q) * eff_size(dim_col_q);
        if (tensor <= 256)
            n = int'(tensor) * $urandom_range(1, 2) + $urandom_range(0, 3);
        else
            n = $urandom_range(4, 24);
        // keep the run close to the item goal
        if (n > budget)
            n = budget;

        gaps_on = !calm && ($urandom_range(0, 3) != 0);
        repeat (n)
        begin
            if (gaps_on && $urandom_range(0, 4) == 0)
                in_gap($urandom_range(1, 11));
            send_element($urandom);
        end
    endtask

    task automatic test_random_traffic();
        while (items_sent < ITEM_GOAL - TAIL_ITEMS)
            run_phase(1'b0, ITEM_GOAL - TAIL_ITEMS - items_sent);
    endtask

    // closing stretch with no idling on either side
    task automatic test_calm_tail();
        int start;
        tail_calm = 1'b1;
        start = items_sent;
        while (items_sent - start < TAIL_ITEMS)
            run_phase(1'b1, TAIL_ITEMS - (items_sent - start));
    endtask

    initial
    begin
        int guard;
        rst_n      = 1'b0;
        cfg_valid  = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        in_valid   = 1'b0;
        element    = '0;
        mismatches = 0;
        items_sent = 0;
        tail_calm  = 1'b0;
        layout_q    = CH_LAST;
        dim_batch_q = tlpa_pkg::CFG_W'(1);
        dim_plane_q = tlpa_pkg::CFG_W'(1);
        dim_row_q   = tlpa_pkg::CFG_W'(1);
        dim_col_q   = tlpa_pkg::CFG_W'(1);
        clear_walk();

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_state();
        test_dim_clamping();
        test_config_restart();
        test_each_layout();
        test_random_traffic();
        test_calm_tail();

        // wait out the owed items, then keep watching for strays before the verdict
        in_gap(1);
        guard = 0;
        while (pending_items.size() != 0 && guard < 20000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (8) @(posedge clk);

        if (pending_items.size() != 0)
            $display("%0t: %0d result items never came, expected %0d actual 0",
                     $time, pending_items.size(), pending_items.size());
        if (mismatches == 0 && pending_items.size() == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

[sim.f]
+incdir+rtl
rtl/tlpa_pkg.sv
rtl/tlpa_stride.sv
rtl/tensor_layout_permute_addresser_core.sv
dv/tb_top.sv
